// File: sv/ipbm_pkg.sv
// Shared types and constants for the idle power-mode battery monitor.
package ipbm_pkg;

	typedef enum logic [1:0] {
		MODE_ACTIVE = 2'd0,
		MODE_DIM    = 2'd1,
		MODE_SLEEP  = 2'd2
	} mode_t;

	localparam int CNT_W      = 32;
	localparam int ADC_W      = 12;
	localparam int MV_W       = 14;
	localparam int PCT_W      = 7;
	localparam int CAL_W      = 16;
	localparam int SCALE_W    = 13;
	localparam int PROD1_W    = ADC_W + CAL_W;
	localparam int PROD2_W    = PROD1_W + SCALE_W;
	localparam int Q15_SHIFT  = 15;
	localparam int DIVIDEND_W = PROD2_W - Q15_SHIFT;
	localparam int DIVISOR_W  = MV_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [SCALE_W-1:0]   ADC_SCALE = 13'd6600;
	localparam logic [DIVISOR_W-1:0] ADC_FULL  = 14'd4095;
	localparam logic [MV_W-1:0]      MV_MAX    = 14'h3FFF;
	localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_IVL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READ_IVL_SLEEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_IVL        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_IVL_SLEEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MV        = 3'd7;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: sv/ipbm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ipbm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ipbm_pkg::div_req_t req,
	output ipbm_pkg::div_rsp_t rsp
);
	import ipbm_pkg::*;

	localparam int STEP_W = $clog2(DIVIDEND_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	always_comb begin
		trial = {rem_q, num_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			// flag done for one cycle after the last quotient bit
			done_q <= !req.start && busy_q && (step_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= req.dividend;
				rem_q  <= '0;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				// shift in the next dividend bit, subtract where it fits
				rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				num_q <= {num_q[DIVIDEND_W-2:0], fits};
				step_q <= step_q + STEP_W'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

// File: sv/idle_power_mode_battery_monitor.sv
// Top level of the idle power-mode manager and battery monitor.
// Usage: the input channel (in_valid/in_ready) carries one item per
// millisecond tick (kind = 0) or per activity event (kind = 1), with the
// averaged 12-bit battery ADC value in adc_average. Every accepted item
// gives exactly one result item on the output channel (out_valid/out_ready):
// the power mode after the item, the last battery reading and percent, and
// the event flags of this item.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one of eight registers; write it only while idle.
// Steps: an activity event or a tick without a battery read is evaluated and
// then goes to the result step. A tick that reads the battery is evaluated,
// multiplied by the calibration factor and then by the ADC scale, and then
// passes through the shared divider twice (ADC to millivolts, then millivolts
// to percent); a flat or inverted calibration skips the percent pass.
// One item is in flight at a time; in_ready is high only while the sequencer
// is idle, so a new item is accepted only once the last is in the output register.
// A result waits in the output register while the receiver stalls, and the
// next item may be accepted meanwhile; its result is held back until the
// earlier one is taken. Reset clears the mode to active, all counters, the
// stored reading, and sets the configuration registers to their defaults.
module idle_power_mode_battery_monitor #(
	parameter int CAL_Q15 = 32768
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [ipbm_pkg::ADC_W-1:0]         adc_average,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         power_mode,
	output logic                               battery_valid,
	output logic [ipbm_pkg::PCT_W-1:0]         battery_percent,
	output logic [ipbm_pkg::MV_W-1:0]          battery_millivolts,
	output logic                               reading_taken,
	output logic                               log_due,
	output logic                               entered_dim,
	output logic                               entered_sleep,
	output logic                               woke_up,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ipbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipbm_pkg::CNT_W-1:0]         cfg_data
);
	import ipbm_pkg::*;

	localparam logic [CAL_W-1:0] CAL = CAL_W'(CAL_Q15);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_MUL1,
		S_MUL2,
		S_MV_GO,
		S_MV_WAIT,
		S_PCT_PREP,
		S_PCT_GO,
		S_PCT_WAIT,
		S_OUT
	} state_t;

	// configuration registers
	logic [CNT_W-1:0] idle_timeout_q;
	logic [CNT_W-1:0] sleep_timeout_q;
	logic [CNT_W-1:0] read_ivl_q;
	logic [CNT_W-1:0] read_ivl_sleep_q;
	logic [CNT_W-1:0] log_ivl_q;
	logic [CNT_W-1:0] log_ivl_sleep_q;
	logic [MV_W-1:0]  empty_mv_q;
	logic [MV_W-1:0]  full_mv_q;

	// block state
	state_t           state_q;
	mode_t            mode_q;
	logic [CNT_W-1:0] idle_cnt_q;
	logic [CNT_W-1:0] read_cnt_q;
	logic [CNT_W-1:0] log_cnt_q;
	logic [MV_W-1:0]  voltage_q;
	logic [PCT_W-1:0] percent_q;
	logic             seen_q;

	// item in flight
	logic             kind_q;
	logic [ADC_W-1:0] adc_q;
	logic             taken_q;
	logic             logd_q;
	logic             dim_q;
	logic             sleep_q;
	logic             woke_q;
	logic [PROD1_W-1:0]    prod1_q;
	logic [PROD2_W-1:0]    prod2_q;
	logic [DIVIDEND_W-1:0] pct_num_q;

	// output register
	logic             out_valid_q;
	mode_t            out_mode_q;
	logic             out_seen_q;
	logic [PCT_W-1:0] out_pct_q;
	logic [MV_W-1:0]  out_mv_q;
	logic             out_taken_q;
	logic             out_logd_q;
	logic             out_dim_q;
	logic             out_sleep_q;
	logic             out_woke_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// tick evaluation
	logic [CNT_W-1:0] idle_inc;
	logic [CNT_W-1:0] read_inc;
	logic [CNT_W-1:0] log_inc;
	logic [CNT_W-1:0] read_ivl;
	logic [CNT_W-1:0] log_ivl;
	logic             take;
	logic             seen_nx;
	logic             logd;
	logic             to_dim;
	logic             to_sleep;

	// conversion helpers
	logic [MV_W-1:0]  mv_sat;
	logic [MV_W-1:0]  mv_clamp;
	logic [PCT_W-1:0] pct_cap;
	logic             cal_bad;

	always_comb begin
		idle_inc = (idle_cnt_q == '1) ? idle_cnt_q : idle_cnt_q + CNT_W'(1);
		read_inc = (read_cnt_q == '1) ? read_cnt_q : read_cnt_q + CNT_W'(1);
		log_inc  = (log_cnt_q == '1) ? log_cnt_q : log_cnt_q + CNT_W'(1);
		read_ivl = (mode_q == MODE_SLEEP) ? read_ivl_sleep_q : read_ivl_q;
		log_ivl  = (mode_q == MODE_SLEEP) ? log_ivl_sleep_q : log_ivl_q;
		take     = (read_inc >= read_ivl);
		seen_nx  = seen_q | take;
		logd     = seen_nx && (log_inc >= log_ivl);
		// mode step uses the mode held before this tick
		to_dim   = (mode_q == MODE_ACTIVE) && (idle_inc >= idle_timeout_q);
		to_sleep = (mode_q == MODE_DIM) && (idle_inc >= sleep_timeout_q);
	end

	always_comb begin
		mv_sat = (div_rsp.quotient > DIVIDEND_W'(MV_MAX)) ? MV_MAX
			: div_rsp.quotient[MV_W-1:0];
		priority if (voltage_q < empty_mv_q) begin
			mv_clamp = empty_mv_q;
		end else if (voltage_q > full_mv_q) begin
			mv_clamp = full_mv_q;
		end else begin
			mv_clamp = voltage_q;
		end
		pct_cap = (div_rsp.quotient > DIVIDEND_W'(PCT_FULL)) ? PCT_FULL
			: div_rsp.quotient[PCT_W-1:0];
		cal_bad = (full_mv_q <= empty_mv_q);
	end

	// feed the shared divider: ADC scale first, then the percent ratio
	always_comb begin
		div_req.start = (state_q == S_MV_GO) || (state_q == S_PCT_GO);
		if (state_q == S_PCT_GO) begin
			div_req.dividend = pct_num_q;
			div_req.divisor  = full_mv_q - empty_mv_q;
		end else begin
			div_req.dividend = prod2_q[PROD2_W-1:Q15_SHIFT];
			div_req.divisor  = ADC_FULL;
		end
	end

	ipbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q   <= CNT_W'(30000);
			sleep_timeout_q  <= CNT_W'(120000);
			read_ivl_q       <= CNT_W'(10000);
			read_ivl_sleep_q <= CNT_W'(60000);
			log_ivl_q        <= CNT_W'(30000);
			log_ivl_sleep_q  <= CNT_W'(300000);
			empty_mv_q       <= MV_W'(3300);
			full_mv_q        <= MV_W'(4200);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_data;
				REG_SLEEP_TIMEOUT:  sleep_timeout_q  <= cfg_data;
				REG_READ_IVL:       read_ivl_q       <= cfg_data;
				REG_READ_IVL_SLEEP: read_ivl_sleep_q <= cfg_data;
				REG_LOG_IVL:        log_ivl_q        <= cfg_data;
				REG_LOG_IVL_SLEEP:  log_ivl_sleep_q  <= cfg_data;
				REG_EMPTY_MV:       empty_mv_q       <= cfg_data[MV_W-1:0];
				REG_FULL_MV:        full_mv_q        <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_ACTIVE;
			idle_cnt_q  <= '0;
			read_cnt_q  <= '0;
			log_cnt_q   <= '0;
			voltage_q   <= '0;
			percent_q   <= '0;
			seen_q      <= 1'b0;
			kind_q      <= 1'b0;
			adc_q       <= '0;
			taken_q     <= 1'b0;
			logd_q      <= 1'b0;
			dim_q       <= 1'b0;
			sleep_q     <= 1'b0;
			woke_q      <= 1'b0;
			prod1_q     <= '0;
			prod2_q     <= '0;
			pct_num_q   <= '0;
			out_valid_q <= 1'b0;
			out_mode_q  <= MODE_ACTIVE;
			out_seen_q  <= 1'b0;
			out_pct_q   <= '0;
			out_mv_q    <= '0;
			out_taken_q <= 1'b0;
			out_logd_q  <= 1'b0;
			out_dim_q   <= 1'b0;
			out_sleep_q <= 1'b0;
			out_woke_q  <= 1'b0;
		end else begin
			// drop the held result once the receiver takes it; the result
			// step reloads the register on its own
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						adc_q   <= adc_average;
						state_q <= S_EVAL;
					end
				end

				S_EVAL: begin
					if (kind_q) begin
						// activity: clear idle time and wake up
						idle_cnt_q <= '0;
						mode_q     <= MODE_ACTIVE;
						taken_q    <= 1'b0;
						logd_q     <= 1'b0;
						dim_q      <= 1'b0;
						sleep_q    <= 1'b0;
						woke_q     <= (mode_q != MODE_ACTIVE);
						state_q    <= S_OUT;
					end else begin
						idle_cnt_q <= idle_inc;
						read_cnt_q <= take ? '0 : read_inc;
						log_cnt_q  <= logd ? '0 : log_inc;
						seen_q     <= seen_nx;
						taken_q    <= take;
						logd_q     <= logd;
						dim_q      <= to_dim;
						sleep_q    <= to_sleep;
						woke_q     <= 1'b0;
						if (to_dim) begin
							mode_q <= MODE_DIM;
						end else if (to_sleep) begin
							mode_q <= MODE_SLEEP;
						end
						state_q <= take ? S_MUL1 : S_OUT;
					end
				end

				S_MUL1: begin
					prod1_q <= PROD1_W'(adc_q) * PROD1_W'(CAL);
					state_q <= S_MUL2;
				end

				S_MUL2: begin
					prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(ADC_SCALE);
					state_q <= S_MV_GO;
				end

				S_MV_GO: begin
					state_q <= S_MV_WAIT;
				end

				S_MV_WAIT: begin
					if (div_rsp.done) begin
						voltage_q <= mv_sat;
						state_q   <= S_PCT_PREP;
					end
				end

				S_PCT_PREP: begin
					if (cal_bad) begin
						percent_q <= '0;
						state_q   <= S_OUT;
					end else begin
						pct_num_q <= DIVIDEND_W'(mv_clamp - empty_mv_q)
							* DIVIDEND_W'(PCT_FULL);
						state_q   <= S_PCT_GO;
					end
				end

				S_PCT_GO: begin
					state_q <= S_PCT_WAIT;
				end

				S_PCT_WAIT: begin
					if (div_rsp.done) begin
						percent_q <= pct_cap;
						state_q   <= S_OUT;
					end
				end

				S_OUT: begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_mode_q  <= mode_q;
						out_seen_q  <= seen_q;
						out_pct_q   <= percent_q;
						out_mv_q    <= voltage_q;
						out_taken_q <= taken_q;
						out_logd_q  <= logd_q;
						out_dim_q   <= dim_q;
						out_sleep_q <= sleep_q;
						out_woke_q  <= woke_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready           = (state_q == S_IDLE);
	assign out_valid          = out_valid_q;
	assign power_mode         = out_mode_q;
	assign battery_valid      = out_seen_q;
	assign battery_percent    = out_pct_q;
	assign battery_millivolts = out_mv_q;
	assign reading_taken      = out_taken_q;
	assign log_due            = out_logd_q;
	assign entered_dim        = out_dim_q;
	assign entered_sleep      = out_sleep_q;
	assign woke_up            = out_woke_q;

endmodule

// File: sv/ipbm_checker.sv
// Port-level checker for the idle power-mode battery monitor, with its bind.
module ipbm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [1:0]                 power_mode,
	input logic                       battery_valid,
	input logic [ipbm_pkg::MV_W-1:0]  battery_millivolts,
	input logic                       reading_taken,
	input logic                       entered_dim,
	input logic                       entered_sleep,
	input logic                       woke_up
);
	import ipbm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(battery_millivolts)
			&& $stable(power_mode))
		else $error("result changed while stalled");

	// at most one mode transition per item
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({entered_dim, entered_sleep, woke_up}))
		else $error("more than one mode transition flagged");

	// dim and wake-up flags agree with the reported mode
	a_dim_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entered_dim |-> power_mode == MODE_DIM)
		else $error("entered dim but mode is not dim");

	a_wake_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && woke_up |-> power_mode == MODE_ACTIVE)
		else $error("woke up but mode is not active");

	// a reading marks the battery value valid
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reading_taken |-> battery_valid)
		else $error("reading taken without valid battery value");

endmodule

bind idle_power_mode_battery_monitor ipbm_checker u_ipbm_checker (.*);
